// ----- hw/rtl/sdtq_pkg.sv -----
// ---------------------------------------------------------------------------
// sdtq_pkg
// Shared constants, types and helpers for the sorted delay task queue.
// ---------------------------------------------------------------------------
package sdtq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W      = 32;
    localparam int HANDLE_W    = 16;

    // Request command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SCHEDULE = 1'b1;

    // Result kind codes
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    // One stored queue entry
    typedef struct packed {
        logic [TICK_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Entry memory access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // Result handed to the output register
    typedef struct packed {
        logic                push;
        logic                kind;
        logic                accepted;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } res_t;

    // Physical slot of logical position off in the ring starting at base
    function automatic logic [ADDR_W-1:0] wrap_addr(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off
    );
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/sdtq_ram.sv -----
// ---------------------------------------------------------------------------
// sdtq_ram
// Entry store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module sdtq_ram (
    input  logic               clk,
    input  sdtq_pkg::ram_req_t req,
    output sdtq_pkg::entry_t   rd_data
);

    sdtq_pkg::entry_t mem [sdtq_pkg::QUEUE_DEPTH];
    sdtq_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sdtq_seq.sv -----
// ---------------------------------------------------------------------------
// sdtq_seq
// Sequencer: walks the ring of entries with one shared deadline comparator,
// inserting on schedule requests and draining due entries on tick requests.
// ---------------------------------------------------------------------------
module sdtq_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic                              command,
    input  logic [sdtq_pkg::TICK_W-1:0]       delay_ticks,
    input  logic [sdtq_pkg::HANDLE_W-1:0]     task_handle,
    input  logic                              res_ready,
    output sdtq_pkg::res_t                    res,
    output sdtq_pkg::ram_req_t                ram_req,
    input  sdtq_pkg::entry_t                  ram_rd_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_FIND_RD  = 10'b00_0000_0010,
        S_FIND_CMP = 10'b00_0000_0100,
        S_SHIFT_RD = 10'b00_0000_1000,
        S_SHIFT_WR = 10'b00_0001_0000,
        S_PUT      = 10'b00_0010_0000,
        S_ANSWER   = 10'b00_0100_0000,
        S_TICK_RD  = 10'b00_1000_0000,
        S_TICK_CMP = 10'b01_0000_0000,
        S_TICK_END = 10'b10_0000_0000
    } state_t;

    state_t                              state_reg, state_next;
    logic [sdtq_pkg::TICK_W-1:0]         tick_reg, tick_next;
    logic [sdtq_pkg::ADDR_W-1:0]         head_reg, head_next;
    logic [sdtq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [sdtq_pkg::CNT_W-1:0]          idx_reg, idx_next;
    logic [sdtq_pkg::CNT_W-1:0]          pos_reg, pos_next;
    logic [sdtq_pkg::TICK_W-1:0]         deadline_reg, deadline_next;
    logic [sdtq_pkg::HANDLE_W-1:0]       handle_reg, handle_next;
    logic                                acc_reg, acc_next;
    logic                                pend_reg, pend_next;

    logic [sdtq_pkg::TICK_W-1:0]         cmp_a;
    logic [sdtq_pkg::TICK_W-1:0]         cmp_b;
    logic                                cmp_le;
    logic                                take;

    assign cmd_stall = (state_reg != S_IDLE);
    assign take      = cmd_valid && (state_reg == S_IDLE);

    // Shared comparator: new deadline vs entry while searching,
    // entry deadline vs tick while draining
    always_comb
    begin
        if (state_reg == S_FIND_CMP)
        begin
            cmp_a = deadline_reg;
            cmp_b = ram_rd_data.deadline;
        end
        else
        begin
            cmp_a = ram_rd_data.deadline;
            cmp_b = tick_reg;
        end
    end
    assign cmp_le = (cmp_a <= cmp_b);

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        deadline_next = deadline_reg;
        handle_next   = handle_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        res           = '0;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    deadline_next = tick_reg + delay_ticks;
                    handle_next   = task_handle;
                    idx_next      = '0;
                    if (command == sdtq_pkg::CMD_SCHEDULE)
                    begin
                        if (count_reg == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_DEPTH))
                        begin
                            acc_next   = 1'b0;
                            state_next = S_ANSWER;
                        end
                        else if (count_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                    else
                    begin
                        tick_next  = tick_reg + 1'b1;
                        pend_next  = 1'b0;
                        state_next = (count_reg == '0) ? S_IDLE : S_TICK_RD;
                    end
                end
            end

            // Search for the first entry not earlier than the new deadline
            S_FIND_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sdtq_pkg::wrap_addr(head_reg, idx_reg);
                state_next      = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (cmp_le)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            // Move entries one slot toward the tail, from the tail down
            S_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = sdtq_pkg::wrap_addr(head_reg, idx_reg - 1'b1);
                    state_next      = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sdtq_pkg::wrap_addr(head_reg, idx_reg);
                ram_req.wr_data = ram_rd_data;
                idx_next        = idx_reg - 1'b1;
                state_next      = S_SHIFT_RD;
            end

            S_PUT:
            begin
                ram_req.wr_en            = 1'b1;
                ram_req.wr_addr          = sdtq_pkg::wrap_addr(head_reg, pos_reg);
                ram_req.wr_data.deadline = deadline_reg;
                ram_req.wr_data.handle   = handle_reg;
                count_next               = count_reg + 1'b1;
                acc_next                 = 1'b1;
                state_next               = S_ANSWER;
            end

            S_ANSWER:
            begin
                if (res_ready)
                begin
                    res.push     = 1'b1;
                    res.kind     = sdtq_pkg::KIND_ANSWER;
                    res.accepted = acc_reg;
                    res.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // Drain due entries from the head
            S_TICK_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = head_reg;
                state_next      = S_TICK_CMP;
            end

            S_TICK_CMP:
            begin
                if (!cmp_le)
                begin
                    state_next = S_TICK_END;
                end
                else if ((ram_rd_data.handle != '0) && pend_reg && !res_ready)
                begin
                    // Held handle still waiting for the output slot
                    state_next = S_TICK_CMP;
                end
                else
                begin
                    if (ram_rd_data.handle != '0)
                    begin
                        // Older held handle is known not to be the last one
                        if (pend_reg)
                        begin
                            res.push   = 1'b1;
                            res.kind   = sdtq_pkg::KIND_FIRED;
                            res.handle = handle_reg;
                        end
                        handle_next = ram_rd_data.handle;
                        pend_next   = 1'b1;
                    end
                    head_next  = sdtq_pkg::wrap_addr(head_reg, sdtq_pkg::CNT_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg == sdtq_pkg::CNT_W'(1)) ? S_TICK_END : S_TICK_RD;
                end
            end

            S_TICK_END:
            begin
                if (!pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (res_ready)
                begin
                    res.push   = 1'b1;
                    res.kind   = sdtq_pkg::KIND_FIRED;
                    res.handle = handle_reg;
                    res.last   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        deadline_reg <= deadline_next;
        handle_reg   <= handle_next;
        acc_reg      <= acc_next;
    end

endmodule

// ----- hw/rtl/sorted_delay_task_queue.sv -----
// ---------------------------------------------------------------------------
// sorted_delay_task_queue
// Deadline-ordered task queue: schedule requests insert in order (refused when full), tick
// requests advance time and report every due task that has a nonzero handle.
// ---------------------------------------------------------------------------
// Time between accepted requests is set by the single-port entry memory walk.
// Schedule: entries are compared from the head to the first one not earlier than the new
//   deadline, later ones move one slot toward the tail, or it is appended; full: refused.
// Tick: a non-empty queue is read from the head, removing due entries until one is not
//   yet due or none is left; both wait while the output register is stalled.
// One request at a time; cmd_stall is high until the request completes.
// Reset: tick count zero and queue empty at once; entry memory not cleared.
// ---------------------------------------------------------------------------
module sorted_delay_task_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic                          command,
    input  logic [sdtq_pkg::TICK_W-1:0]   delay_ticks,
    input  logic [sdtq_pkg::HANDLE_W-1:0] task_handle,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          kind,
    output logic                          accepted,
    output logic [sdtq_pkg::HANDLE_W-1:0] fired_handle,
    output logic                          last
);

    sdtq_pkg::ram_req_t            ram_req;
    sdtq_pkg::entry_t              ram_rd_data;
    sdtq_pkg::res_t                res;
    logic                          res_ready;
    logic                          valid_reg, valid_next;
    logic                          kind_reg;
    logic                          accepted_reg;
    logic [sdtq_pkg::HANDLE_W-1:0] handle_reg;
    logic                          last_reg;

    sdtq_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    sdtq_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .delay_ticks (delay_ticks),
        .task_handle (task_handle),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // Output register: free when empty or being taken this cycle
    assign res_ready = !valid_reg || !res_stall;

    always_comb
    begin
        if (res.push)
        begin
            valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            kind_reg     <= res.kind;
            accepted_reg <= res.accepted;
            handle_reg   <= res.handle;
            last_reg     <= res.last;
        end
    end

    assign res_valid    = valid_reg;
    assign kind         = kind_reg;
    assign accepted     = accepted_reg;
    assign fired_handle = handle_reg;
    assign last         = last_reg;

    // Checks
    a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> res_ready)
        else $error("result pushed into an occupied output register");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |=> res_valid)
        else $error("pushed result not presented");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> !ram_req.wr_en)
        else $error("entry memory written while idle");

    a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (kind == sdtq_pkg::KIND_ANSWER)) |-> (last && (fired_handle == '0)))
        else $error("schedule answer malformed");

    a_fired_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (kind == sdtq_pkg::KIND_FIRED)) |-> ((fired_handle != '0) && !accepted))
        else $error("fired result with zero handle or accepted flag");

endmodule
